// ===== rtl/pwt_pkg.sv =====
// Package with payload types and codes of the four-level page table walker.
package pwt_pkg;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_RAW   = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd1;
  localparam logic [2:0] ST_HUGE        = 3'd2;
  localparam logic [2:0] ST_NO_FRAMES   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE     = 3'd4;

  localparam int unsigned BIT_P  = 0;
  localparam int unsigned BIT_PS = 7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] page_flags;
    logic [3:0]  raw_frame;
    logic [8:0]  raw_slot;
    logic [63:0] raw_value;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [2:0]  status;
    logic [51:0] translated_addr;
    logic [11:0] entry_flags;
    logic        tlb_invalidate;
    logic [35:0] invalidate_page;
  } rsp_t;

endpackage

// ===== rtl/pwt_if.sv =====
// Handshake interfaces for the request, response and configuration channels.
interface pwt_req_if;
  import pwt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwt_rsp_if;
  import pwt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwt_cfg_if;
  logic        valid;
  logic        ready;
  logic [51:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pwt_mem.sv =====
// Table memory: one write port and one read port with registered read data.
module pwt_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);
  logic [63:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// Top level of the four-level page table walker over an internal frame pool.
//
//  channel  direction  carries
//  req_i    in         one operation item (map, unmap, query, raw write)
//  rsp_o    out        one result item per operation
//  cfg_i    in         pool base address
//
// A raw write goes straight to the memory on acceptance; a walk reads one table entry
// per level through the single read port of the table memory, and a map or unmap
// writes the leaf without reading it. Every table a map allocates is cleared first.
// After reset the whole memory, POOL_FRAMES*ENTRIES_PER_TABLE entries, is cleared entry
// by entry before the first item is accepted; configuration writes are taken.
// A result waits in the output register; the next item may enter meanwhile.
module four_level_page_table_walker #(
  parameter int unsigned POOL_FRAMES       = 16,
  parameter int unsigned ENTRIES_PER_TABLE = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  pwt_req_if.sink   req_i,
  pwt_rsp_if.source rsp_o,
  pwt_cfg_if.sink   cfg_i
);
  import pwt_pkg::*;

  localparam int unsigned DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned IW    = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned FW    = $clog2(POOL_FRAMES);
  localparam int unsigned AW    = FW + IW;
  localparam int unsigned NW    = $clog2(POOL_FRAMES + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_EV, S_CLR, S_WENT, S_FIN
  } state_e;

  state_e        state_q;
  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] clr_end_q;
  logic [NW-1:0] nff_q;
  logic [51:0]   base_q;
  logic [1:0]    op_q;
  logic [47:0]   va_q;
  logic [51:0]   pa_q;
  logic [11:0]   flags_q;
  logic [1:0]    lvl_q;
  logic [FW-1:0] cur_q;
  logic [FW-1:0] newf_q;
  logic [39:0]   newpn_q;
  rsp_t          res_q;
  rsp_t          out_q;
  logic          out_valid_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;
  logic [IW-1:0] idx;
  logic          accept;
  logic          raw_oob;
  logic [39:0]   e_pn;
  logic [39:0]   diff;
  logic          outside;
  logic [FW-1:0] e_frame;

  function automatic rsp_t mk_rsp(logic [2:0] st, logic [51:0] taddr, logic [11:0] fl,
                                  logic inv, logic [47:0] va);
    rsp_t r;
    r.success         = (st == ST_OK);
    r.status          = st;
    r.translated_addr = (st == ST_OK) ? taddr : '0;
    r.entry_flags     = (st == ST_OK) ? fl : '0;
    r.tlb_invalidate  = (st == ST_OK) && inv;
    r.invalidate_page = ((st == ST_OK) && inv) ? va[47:12] : '0;
    return r;
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign raw_oob     = 11'(req_i.data.raw_frame) >= 11'(POOL_FRAMES);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    case (lvl_q)
      2'd3:    idx = va_q[47:39];
      2'd2:    idx = va_q[38:30];
      2'd1:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  // Translate a table pointer into a pool frame number.
  assign e_pn    = mem_rdata[51:12];
  assign diff    = e_pn - base_q[51:12];
  assign outside = (e_pn < base_q[51:12]) || (diff >= 40'(POOL_FRAMES));
  assign e_frame = diff[FW-1:0];

  assign mem_raddr = {cur_q, idx};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_q, idx};
    mem_wdata = '0;
    case (state_q)
      S_INIT, S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
      end
      S_IDLE: begin
        mem_we    = accept && (req_i.data.opcode == OP_RAW) && !raw_oob;
        mem_waddr = {FW'(req_i.data.raw_frame), req_i.data.raw_slot};
        mem_wdata = req_i.data.raw_value;
      end
      S_RD: begin
        // Map and unmap write the leaf without reading it.
        mem_we    = (lvl_q == 2'd0) && (op_q != OP_QUERY);
        mem_wdata = (op_q == OP_MAP) ? {12'h000, pa_q[51:12], flags_q | 12'h001} : '0;
      end
      S_WENT: begin
        mem_we    = 1'b1;
        mem_wdata = {12'h000, newpn_q, 12'h003};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pwt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_addr_q  <= '0;
      clr_end_q   <= AW'(DEPTH - 1);
      nff_q       <= NW'(1);
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        base_q <= cfg_i.data;
      end
      if (out_valid_q && rsp_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == clr_end_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= req_i.data.opcode;
            va_q    <= req_i.data.virt_addr;
            pa_q    <= req_i.data.phys_addr;
            flags_q <= req_i.data.page_flags;
            cur_q   <= '0;
            lvl_q   <= 2'd3;
            if (req_i.data.opcode == OP_RAW) begin
              res_q   <= mk_rsp(raw_oob ? ST_OUTSIDE : ST_OK, '0, '0, 1'b0, '0);
              state_q <= S_FIN;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          if ((lvl_q == 2'd0) && (op_q != OP_QUERY)) begin
            res_q   <= mk_rsp(ST_OK, '0, '0, 1'b1, va_q);
            state_q <= S_FIN;
          end else begin
            state_q <= S_EV;
          end
        end
        S_EV: begin
          state_q <= S_RD;
          if (op_q == OP_MAP) begin
            if ((lvl_q == 2'd1) && mem_rdata[BIT_PS]) begin
              res_q   <= mk_rsp(ST_HUGE, '0, '0, 1'b0, va_q);
              state_q <= S_FIN;
            end else if (!mem_rdata[BIT_P]) begin
              if (nff_q >= NW'(POOL_FRAMES)) begin
                res_q   <= mk_rsp(ST_NO_FRAMES, '0, '0, 1'b0, va_q);
                state_q <= S_FIN;
              end else begin
                newf_q     <= FW'(nff_q);
                newpn_q    <= base_q[51:12] + 40'(nff_q);
                clr_addr_q <= {FW'(nff_q), {IW{1'b0}}};
                clr_end_q  <= {FW'(nff_q), {IW{1'b1}}};
                nff_q      <= nff_q + NW'(1);
                state_q    <= S_CLR;
              end
            end else if (outside) begin
              res_q   <= mk_rsp(ST_OUTSIDE, '0, '0, 1'b0, va_q);
              state_q <= S_FIN;
            end else begin
              cur_q <= e_frame;
              lvl_q <= lvl_q - 2'd1;
            end
          end else begin
            if (!mem_rdata[BIT_P]) begin
              res_q   <= mk_rsp(ST_NOT_PRESENT, '0, '0, 1'b0, va_q);
              state_q <= S_FIN;
            end else if ((lvl_q == 2'd1) && mem_rdata[BIT_PS]) begin
              if (op_q == OP_UNMAP) begin
                res_q <= mk_rsp(ST_HUGE, '0, '0, 1'b0, va_q);
              end else begin
                res_q <= mk_rsp(ST_OK, {mem_rdata[51:21], va_q[20:0]},
                                mem_rdata[11:0], 1'b0, va_q);
              end
              state_q <= S_FIN;
            end else if (lvl_q == 2'd0) begin
              res_q   <= mk_rsp(ST_OK, {mem_rdata[51:12], va_q[11:0]},
                                mem_rdata[11:0], 1'b0, va_q);
              state_q <= S_FIN;
            end else if (outside) begin
              res_q   <= mk_rsp(ST_OUTSIDE, '0, '0, 1'b0, va_q);
              state_q <= S_FIN;
            end else begin
              cur_q <= e_frame;
              lvl_q <= lvl_q - 2'd1;
            end
          end
        end
        S_CLR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == clr_end_q) begin
            state_q <= S_WENT;
          end
        end
        S_WENT: begin
          cur_q   <= newf_q;
          lvl_q   <= lvl_q - 2'd1;
          state_q <= S_RD;
        end
        S_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_nff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nff_q <= NW'(POOL_FRAMES))
    else $error("free frame counter beyond pool");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < DEPTH))
    else $error("table write outside memory");

  a_alloc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV) && (state_q != $past(state_q)) |-> $past(state_q) == S_RD)
    else $error("evaluation without a preceding read");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && (!out_valid_q || rsp_o.ready) |=> out_valid_q)
    else $error("finished item not presented");
`endif
endmodule
